/* rtl/core/wsp_pkg.sv */
// shared types and constants for the world to screen projection pipeline
`timescale 1ns / 1ps

package wsp_pkg;

   localparam int COORD_W  = 32;
   localparam int SIZE_W   = 14;
   localparam int HALF_W   = SIZE_W - 1;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 64;
   localparam int QUOT_W   = 41;
   localparam int ROWS     = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROW_X_AB  = 3'd0,
      CSR_ROW_X_CD  = 3'd1,
      CSR_ROW_Y_AB  = 3'd2,
      CSR_ROW_Y_CD  = 3'd3,
      CSR_ROW_W_AB  = 3'd4,
      CSR_ROW_W_CD  = 3'd5,
      CSR_SCREEN_W  = 3'd6,
      CSR_SCREEN_H  = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic              visible;
      logic              negate;
      logic [HALF_W-1:0] half;
   } side_type;

endpackage

/* rtl/core/world_to_screen_projection.sv */
// perspective projection and viewport mapping of one point per cycle while the result is not stalled
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  pos_x, pos_y, pos_z
//   rsp      out        rsp_valid / rsp_stall  visible, screen_x, screen_y
//   csr      in         csr_we                 csr_index, csr_wdata
//
// one point enters per cycle unless a result is stalled; points pass the five front stages, then the divider stages
// one quotient bit per stage, two dividers side by side for x and y
// a stalled result freezes the whole pipeline, nothing is dropped or repeated
// synchronous reset clears valid bits and loads the default matrix and viewport
`timescale 1ns / 1ps

module world_to_screen_projection #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [wsp_pkg::COORD_W-1:0]   req_pos_x,
   input  logic signed [wsp_pkg::COORD_W-1:0]   req_pos_y,
   input  logic signed [wsp_pkg::COORD_W-1:0]   req_pos_z,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_visible,
   output logic signed [wsp_pkg::COORD_W-1:0]   rsp_screen_x,
   output logic signed [wsp_pkg::COORD_W-1:0]   rsp_screen_y,
   input  logic                                 csr_we,
   input  logic [wsp_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [wsp_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   localparam int CW     = wsp_pkg::COORD_W;
   localparam int PROD_W = 2 * CW;
   localparam int SUM_W  = PROD_W + 2;
   localparam int CLIP_W = SUM_W + 1 - FRAC_BITS;
   localparam int HW     = wsp_pkg::HALF_W;
   localparam int MUL_W  = CLIP_W + HW;
   localparam int NUM_W  = MUL_W + FRAC_BITS;
   localparam int QW     = wsp_pkg::QUOT_W;
   localparam int RES_W  = QW + 2;
   localparam logic [CLIP_W-1:0] W_MIN = CLIP_W'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);
   localparam logic signed [RES_W-1:0] S_MAX = RES_W'(64'sh7FFFFFFF);
   localparam logic signed [RES_W-1:0] S_MIN = -RES_W'(64'sh80000000);

   logic [wsp_pkg::CSR_DATA_W-1:0] row_ab_ff [wsp_pkg::ROWS];
   logic [wsp_pkg::CSR_DATA_W-1:0] row_cd_ff [wsp_pkg::ROWS];
   logic [wsp_pkg::SIZE_W-1:0]     width_ff;
   logic [wsp_pkg::SIZE_W-1:0]     height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ab_ff[0] <= 64'd65536;
         row_cd_ff[0] <= 64'd0;
         row_ab_ff[1] <= 64'd281474976710656;
         row_cd_ff[1] <= 64'd0;
         row_ab_ff[2] <= 64'd0;
         row_cd_ff[2] <= 64'd281474976710656;
         width_ff     <= 14'd1920;
         height_ff    <= 14'd1080;
      end else if (csr_we) begin
         case (wsp_pkg::csr_index_type'(csr_index))
            wsp_pkg::CSR_ROW_X_AB: row_ab_ff[0] <= csr_wdata;
            wsp_pkg::CSR_ROW_X_CD: row_cd_ff[0] <= csr_wdata;
            wsp_pkg::CSR_ROW_Y_AB: row_ab_ff[1] <= csr_wdata;
            wsp_pkg::CSR_ROW_Y_CD: row_cd_ff[1] <= csr_wdata;
            wsp_pkg::CSR_ROW_W_AB: row_ab_ff[2] <= csr_wdata;
            wsp_pkg::CSR_ROW_W_CD: row_cd_ff[2] <= csr_wdata;
            wsp_pkg::CSR_SCREEN_W: width_ff     <= csr_wdata[wsp_pkg::SIZE_W-1:0];
            wsp_pkg::CSR_SCREEN_H: height_ff    <= csr_wdata[wsp_pkg::SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   logic en;
   logic rsp_valid_ff;
   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;

   // stage 1: products
   logic signed [PROD_W-1:0] prod_ff [wsp_pkg::ROWS][3];
   logic                     v1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_valid;
      end
   end

   for (genvar r = 0; r < wsp_pkg::ROWS; r++) begin : g_row
      logic signed [CW-1:0]     ca, cb, cc, tr;
      logic signed [SUM_W-1:0]  sum_ff;
      logic signed [SUM_W-1:0]  shifted;
      logic signed [CLIP_W-1:0] clip_ff;

      assign ca = row_ab_ff[r][CW-1:0];
      assign cb = row_ab_ff[r][2*CW-1:CW];
      assign cc = row_cd_ff[r][CW-1:0];
      assign tr = row_cd_ff[r][2*CW-1:CW];
      assign shifted = sum_ff >>> FRAC_BITS;

      always_ff @(posedge clock) begin
         if (en) begin
            prod_ff[r][0] <= ca * req_pos_x;
            prod_ff[r][1] <= cb * req_pos_y;
            prod_ff[r][2] <= cc * req_pos_z;
            sum_ff  <= SUM_W'(prod_ff[r][0]) + SUM_W'(prod_ff[r][1]) + SUM_W'(prod_ff[r][2]);
            clip_ff <= shifted[CLIP_W-1:0] + CLIP_W'(tr);
         end
      end
   end

   // stages 2 and 3: row sums, then floor and translation
   logic v2_ff, v3_ff;

   // stage 4: visibility, magnitudes and signs
   logic              v4_ff, vis4_ff, negx4_ff, negy4_ff;
   logic [CLIP_W-1:0] magx4_ff, magy4_ff, den4_ff;
   logic [HW-1:0]     halfw4_ff, halfh4_ff;
   logic signed [CLIP_W-1:0] cx, cy, cwv;

   assign cx  = g_row[0].clip_ff;
   assign cy  = g_row[1].clip_ff;
   assign cwv = g_row[2].clip_ff;

   // stage 5: scaled numerators
   logic              v5_ff;
   logic [MUL_W-1:0]  mulx5_ff, muly5_ff;
   logic [CLIP_W-1:0] den5_ff;
   wsp_pkg::side_type sidex5_ff, sidey5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
      if (en) begin
         vis4_ff   <= (cwv >= $signed(W_MIN));
         negx4_ff  <= cx[CLIP_W-1];
         negy4_ff  <= !cy[CLIP_W-1];
         magx4_ff  <= cx[CLIP_W-1] ? CLIP_W'(-cx) : CLIP_W'(cx);
         magy4_ff  <= cy[CLIP_W-1] ? CLIP_W'(-cy) : CLIP_W'(cy);
         den4_ff   <= CLIP_W'(cwv);
         halfw4_ff <= width_ff[wsp_pkg::SIZE_W-1:1];
         halfh4_ff <= height_ff[wsp_pkg::SIZE_W-1:1];
         mulx5_ff  <= MUL_W'(magx4_ff) * MUL_W'(halfw4_ff);
         muly5_ff  <= MUL_W'(magy4_ff) * MUL_W'(halfh4_ff);
         den5_ff   <= den4_ff;
         sidex5_ff <= '{visible: vis4_ff, negate: negx4_ff, half: halfw4_ff};
         sidey5_ff <= '{visible: vis4_ff, negate: negy4_ff, half: halfh4_ff};
      end
   end

   logic              dvx_valid, dvy_valid;
   logic [QW-1:0]     qx, qy;
   wsp_pkg::side_type sx, sy;

   wsp_div #(.NUM_W(NUM_W), .DEN_W(CLIP_W), .QUOT_W(QW)) u_div_x (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(v5_ff), .in_num({mulx5_ff, {FRAC_BITS{1'b0}}}), .in_den(den5_ff),
      .in_side(sidex5_ff),
      .out_valid(dvx_valid), .out_quot(qx), .out_side(sx)
   );

   wsp_div #(.NUM_W(NUM_W), .DEN_W(CLIP_W), .QUOT_W(QW)) u_div_y (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(v5_ff), .in_num({muly5_ff, {FRAC_BITS{1'b0}}}), .in_den(den5_ff),
      .in_side(sidey5_ff),
      .out_valid(dvy_valid), .out_quot(qy), .out_side(sy)
   );

   // output stage: offset, sign and saturation
   logic signed [RES_W-1:0] basex, basey, rx, ry;
   logic signed [CW-1:0]    satx, saty;
   logic signed [CW-1:0]    screen_x_ff, screen_y_ff;
   logic                    visible_ff;

   assign basex = $signed(RES_W'({sx.half, {FRAC_BITS{1'b0}}}));
   assign basey = $signed(RES_W'({sy.half, {FRAC_BITS{1'b0}}}));
   assign rx = sx.negate ? basex - $signed(RES_W'(qx)) : basex + $signed(RES_W'(qx));
   assign ry = sy.negate ? basey - $signed(RES_W'(qy)) : basey + $signed(RES_W'(qy));
   assign satx = (rx > S_MAX) ? CW'(S_MAX) : ((rx < S_MIN) ? CW'(S_MIN) : rx[CW-1:0]);
   assign saty = (ry > S_MAX) ? CW'(S_MAX) : ((ry < S_MIN) ? CW'(S_MIN) : ry[CW-1:0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= dvx_valid && dvy_valid;
      end
      if (en) begin
         visible_ff  <= sx.visible;
         screen_x_ff <= sx.visible ? satx : '0;
         screen_y_ff <= sy.visible ? saty : '0;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_visible  = visible_ff;
   assign rsp_screen_x = screen_x_ff;
   assign rsp_screen_y = screen_y_ff;

   a_hidden_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_visible |-> rsp_screen_x == '0 && rsp_screen_y == '0)
      else $error("hidden point with nonzero coordinates");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_lanes_aligned: assert property (@(posedge clock) disable iff (reset)
      dvx_valid == dvy_valid)
      else $error("divider lanes out of step");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with no result pending");

endmodule

/* rtl/core/wsp_div.sv */
// pipelined restoring divider with quotient capped at the top quotient bit
`timescale 1ns / 1ps

module wsp_div #(
   parameter int NUM_W  = 80,
   parameter int DEN_W  = 51,
   parameter int QUOT_W = 41
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    in_valid,
   input  logic [NUM_W-1:0]        in_num,
   input  logic [DEN_W-1:0]        in_den,
   input  wsp_pkg::side_type       in_side,
   output logic                    out_valid,
   output logic [QUOT_W-1:0]       out_quot,
   output wsp_pkg::side_type       out_side
);

   localparam int HI_W  = NUM_W - QUOT_W;
   localparam int REM_W = ((DEN_W > HI_W) ? DEN_W : HI_W) + 1;
   localparam logic [QUOT_W-1:0] CAP = QUOT_W'(1) << (QUOT_W - 1);

   logic [REM_W-1:0]  rem_ff  [QUOT_W+1];
   logic [QUOT_W-1:0] lo_ff   [QUOT_W+1];
   logic [QUOT_W-1:0] quo_ff  [QUOT_W+1];
   logic [DEN_W-1:0]  den_ff  [QUOT_W+1];
   logic              ovf_ff  [QUOT_W+1];
   wsp_pkg::side_type side_ff [QUOT_W+1];
   logic              valid_ff[QUOT_W+1];

   logic [REM_W-1:0] rem0_in;
   logic [REM_W-1:0] den0_ext;

   assign rem0_in  = REM_W'(in_num[NUM_W-1:QUOT_W]);
   assign den0_ext = REM_W'(in_den);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= in_valid;
      end
      if (en) begin
         rem_ff[0]  <= rem0_in;
         lo_ff[0]   <= in_num[QUOT_W-1:0];
         quo_ff[0]  <= '0;
         den_ff[0]  <= in_den;
         ovf_ff[0]  <= (rem0_in >= den0_ext);
         side_ff[0] <= in_side;
      end
   end

   for (genvar k = 0; k < QUOT_W; k++) begin : g_step
      logic [REM_W:0]   trial;
      logic [REM_W:0]   den_x;
      logic             ge;
      logic [REM_W:0]   diff;

      assign trial = {rem_ff[k], lo_ff[k][QUOT_W-1]};
      assign den_x = (REM_W + 1)'(den_ff[k]);
      assign ge    = (trial >= den_x);
      assign diff  = trial - den_x;

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k+1] <= 1'b0;
         end else if (en) begin
            valid_ff[k+1] <= valid_ff[k];
         end
         if (en) begin
            rem_ff[k+1]  <= ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
            lo_ff[k+1]   <= {lo_ff[k][QUOT_W-2:0], 1'b0};
            quo_ff[k+1]  <= {quo_ff[k][QUOT_W-2:0], ge};
            den_ff[k+1]  <= den_ff[k];
            ovf_ff[k+1]  <= ovf_ff[k];
            side_ff[k+1] <= side_ff[k];
         end
      end
   end

   assign out_valid = valid_ff[QUOT_W];
   assign out_side  = side_ff[QUOT_W];
   assign out_quot  = (ovf_ff[QUOT_W] || (quo_ff[QUOT_W] > CAP)) ? CAP : quo_ff[QUOT_W];

endmodule
